// File: rtl/core/delta_list_timer_queue_defines.svh
// assertion macros for the delta list timer queue
`ifndef DELTA_LIST_TIMER_QUEUE_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define DLTQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define DLTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/dltq_pkg.sv
package dltq_pkg;

    localparam logic [1:0] MODE_SET    = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EXPIRED   = 3'd3;
    localparam logic [2:0] ST_IDLE      = 3'd4;

    localparam int MAX_RESULTS = 16;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_WALK,
        S_SET_END,
        S_DEL_FIX,
        S_TICK_HEAD,
        S_TICK_CHK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] delay;
        logic [7:0]  queue_id;
        logic [31:0] message;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  event_queue;
        logic [31:0] event_message;
        logic        last;
    } rsp_t;

endpackage

// File: rtl/core/dltq_req_if.sv
interface dltq_req_if;
    logic              valid;
    logic              ready;
    dltq_pkg::req_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/dltq_rsp_if.sv
interface dltq_rsp_if;
    logic              valid;
    logic              ready;
    dltq_pkg::rsp_t    payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/dltq_table.sv
// entry table: links, deltas, queue ids and messages; one shared read address, a write port per store
module dltq_table #(
    parameter int NUM_ENTRIES = 16,
    parameter int IW = 5
) (
    input  logic          clk,
    input  logic          init_we,
    input  logic [IW-1:0] init_idx,
    input  logic          link_we,
    input  logic [IW-1:0] link_waddr,
    input  logic [IW-1:0] link_wdata,
    input  logic          delta_we,
    input  logic [IW-1:0] delta_waddr,
    input  logic [15:0]   delta_wdata,
    input  logic          data_we,
    input  logic [IW-1:0] data_waddr,
    input  logic [7:0]    queue_wdata,
    input  logic [31:0]   message_wdata,
    input  logic [IW-1:0] raddr,
    output logic [IW-1:0] link_rdata,
    output logic [15:0]   delta_rdata,
    output logic [7:0]    queue_rdata,
    output logic [31:0]   message_rdata
);
    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic [IW-1:0] link_mem [NUM_ENTRIES];
    logic [15:0]   delta_mem [NUM_ENTRIES];
    logic [7:0]    queue_mem [NUM_ENTRIES];
    logic [31:0]   message_mem [NUM_ENTRIES];

    // link store, chained at init sweep
    always_ff @(posedge clk)
    begin
        if (init_we)
        begin
            link_mem[init_idx[AW-1:0]] <= init_idx + IW'(1);
        end
        else if (link_we)
        begin
            link_mem[link_waddr[AW-1:0]] <= link_wdata;
        end
        link_rdata <= link_mem[raddr[AW-1:0]];
    end

    // delta store
    always_ff @(posedge clk)
    begin
        if (delta_we)
        begin
            delta_mem[delta_waddr[AW-1:0]] <= delta_wdata;
        end
        delta_rdata <= delta_mem[raddr[AW-1:0]];
    end

    // event data store
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            queue_mem[data_waddr[AW-1:0]]   <= queue_wdata;
            message_mem[data_waddr[AW-1:0]] <= message_wdata;
        end
        queue_rdata   <= queue_mem[raddr[AW-1:0]];
        message_rdata <= message_mem[raddr[AW-1:0]];
    end
endmodule

// File: rtl/core/delta_list_timer_queue.sv
// Delta list timer queue. Keeps NUM_ENTRIES timed events as a linked delta
// list plus a free list, in one table with a shared read port. After reset
// a link initialization sweep over all NUM_ENTRIES entries runs before the
// first request is taken. One request is worked at a time under a small
// sequencer: a set or delete walks the list one entry at a time (registered
// table read, then compare, and for a set subtract, in the shared adder); a
// tick takes the expired events off the head one at a time, each result
// waiting in the output register until taken. Mode 3 requests are consumed
// with no result.
`include "delta_list_timer_queue_defines.svh"
module delta_list_timer_queue #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    dltq_req_if.sink    req,
    dltq_rsp_if.source  rsp
);
    localparam int IW = $clog2(NUM_ENTRIES + 1);
    localparam logic [IW-1:0] EMPTY = IW'(NUM_ENTRIES);
    localparam int CW = $clog2(dltq_pkg::MAX_RESULTS + 1);

    dltq_pkg::state_t state_reg, state_next;
    dltq_pkg::req_t   cmd_reg, cmd_next;
    logic [IW-1:0] free_reg, free_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic [IW-1:0] ent_reg, ent_next;
    logic [IW-1:0] init_reg, init_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   dly_reg, dly_next;
    logic [15:0]   cdelta_reg, cdelta_next;
    dltq_pkg::rsp_t out_reg, out_next;
    logic          ovalid_reg, ovalid_next;

    logic          link_we, delta_we, data_we;
    logic [IW-1:0] link_waddr, link_wdata, delta_waddr, raddr;
    logic [15:0]   delta_wdata;
    logic [IW-1:0] link_rdata;
    logic [15:0]   delta_rdata;
    logic [7:0]    queue_rdata;
    logic [31:0]   message_rdata;

    // shared adder/subtractor
    logic          alu_sub;
    logic [15:0]   alu_a, alu_b;
    logic [16:0]   alu_y;
    always_comb
    begin
        alu_y = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
    end

    logic is_match;
    assign is_match = (queue_rdata == cmd_reg.queue_id) && (message_rdata == cmd_reg.message);

    dltq_table #(.NUM_ENTRIES(NUM_ENTRIES), .IW(IW)) u_table (
        .clk           (clk),
        .init_we       (state_reg == dltq_pkg::S_INIT),
        .init_idx      (init_reg),
        .link_we       (link_we),
        .link_waddr    (link_waddr),
        .link_wdata    (link_wdata),
        .delta_we      (delta_we),
        .delta_waddr   (delta_waddr),
        .delta_wdata   (delta_wdata),
        .data_we       (data_we),
        .data_waddr    (free_reg),
        .queue_wdata   (cmd_reg.queue_id),
        .message_wdata (cmd_reg.message),
        .raddr         (raddr),
        .link_rdata    (link_rdata),
        .delta_rdata   (delta_rdata),
        .queue_rdata   (queue_rdata),
        .message_rdata (message_rdata)
    );

    assign req.ready   = (state_reg == dltq_pkg::S_IDLE);
    assign rsp.valid   = ovalid_reg;
    assign rsp.payload = out_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dltq_pkg::S_INIT;
            free_reg   <= '0;
            head_reg   <= EMPTY;
            init_reg   <= '0;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            free_reg   <= free_next;
            head_reg   <= head_next;
            init_reg   <= init_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        ent_reg    <= ent_next;
        dly_reg    <= dly_next;
        cdelta_reg <= cdelta_next;
        out_reg    <= out_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dltq_pkg::S_INIT:
            begin
                if (init_reg == IW'(NUM_ENTRIES - 1))
                    state_next = dltq_pkg::S_IDLE;
            end
            dltq_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.payload.mode)
                        dltq_pkg::MODE_SET:
                            state_next = (free_reg == EMPTY) ? dltq_pkg::S_OUT
                                                             : dltq_pkg::S_RD;
                        dltq_pkg::MODE_DELETE:
                            state_next = dltq_pkg::S_RD;
                        dltq_pkg::MODE_TICK:
                            state_next = dltq_pkg::S_RD;
                        default:
                            state_next = dltq_pkg::S_IDLE;
                    endcase
                end
            end
            dltq_pkg::S_RD:
            begin
                if (cmd_reg.mode == dltq_pkg::MODE_TICK)
                    state_next = (head_reg == EMPTY) ? dltq_pkg::S_OUT
                                                     : dltq_pkg::S_TICK_HEAD;
                else if (cur_reg == EMPTY)
                    state_next = (cmd_reg.mode == dltq_pkg::MODE_SET) ? dltq_pkg::S_SET_END
                                                                      : dltq_pkg::S_OUT;
                else
                    state_next = dltq_pkg::S_WALK;
            end
            dltq_pkg::S_WALK:
            begin
                if (cmd_reg.mode == dltq_pkg::MODE_SET)
                    state_next = (delta_rdata > dly_reg) ? dltq_pkg::S_SET_END
                                                         : dltq_pkg::S_RD;
                else if (is_match)
                    state_next = dltq_pkg::S_DEL_FIX;
                else
                    state_next = dltq_pkg::S_RD;
            end
            dltq_pkg::S_SET_END:
                state_next = dltq_pkg::S_OUT;
            dltq_pkg::S_DEL_FIX:
                state_next = dltq_pkg::S_OUT;
            dltq_pkg::S_TICK_HEAD:
                state_next = dltq_pkg::S_TICK_CHK;
            dltq_pkg::S_TICK_CHK:
                state_next = dltq_pkg::S_OUT;
            dltq_pkg::S_OUT:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    if (out_reg.last || !ovalid_reg)
                        state_next = ovalid_reg ? dltq_pkg::S_IDLE : dltq_pkg::S_OUT;
                    else
                        state_next = dltq_pkg::S_RD;
                end
            end
            default:
                state_next = dltq_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next    = cmd_reg;
        free_next   = free_reg;
        head_next   = head_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        ent_next    = ent_reg;
        init_next   = init_reg;
        cnt_next    = cnt_reg;
        dly_next    = dly_reg;
        cdelta_next = cdelta_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        link_we     = 1'b0;
        link_waddr  = cur_reg;
        link_wdata  = cur_reg;
        delta_we    = 1'b0;
        delta_waddr = cur_reg;
        delta_wdata = alu_y[15:0];
        data_we     = 1'b0;
        raddr       = cur_reg;
        alu_sub     = 1'b1;
        alu_a       = dly_reg;
        alu_b       = delta_rdata;
        unique case (state_reg)
            dltq_pkg::S_INIT:
                init_next = init_reg + IW'(1);
            dltq_pkg::S_IDLE:
            begin
                cmd_next  = req.payload;
                cur_next  = head_reg;
                prev_next = EMPTY;
                dly_next  = req.payload.delay;
                cnt_next  = '0;
                out_next  = '{status: dltq_pkg::ST_OK, event_queue: 8'd0,
                              event_message: 32'd0, last: 1'b1};
                if (req.valid && req.payload.mode == dltq_pkg::MODE_SET)
                begin
                    if (free_reg == EMPTY)
                    begin
                        out_next.status = dltq_pkg::ST_FULL;
                        ovalid_next     = 1'b1;
                    end
                    else
                        raddr = free_reg;
                end
                if (req.valid && req.payload.mode == dltq_pkg::MODE_TICK)
                    cur_next = head_reg;
            end
            dltq_pkg::S_RD:
            begin
                // first set cycle: free list successor arrives in link_rdata
                if (cmd_reg.mode == dltq_pkg::MODE_SET && prev_reg == EMPTY)
                    ent_next = link_rdata;
                raddr = cur_reg;
                if (cmd_reg.mode == dltq_pkg::MODE_TICK)
                begin
                    raddr = head_reg;
                    if (head_reg == EMPTY)
                    begin
                        out_next = '{status: dltq_pkg::ST_IDLE, event_queue: 8'd0,
                                     event_message: 32'd0, last: 1'b1};
                        ovalid_next = 1'b1;
                    end
                end
                else if (cur_reg == EMPTY)
                begin
                    if (cmd_reg.mode == dltq_pkg::MODE_DELETE)
                    begin
                        out_next.status = dltq_pkg::ST_NOT_FOUND;
                        ovalid_next = 1'b1;
                    end
                    else if (prev_reg != EMPTY)
                    begin
                        // append after the tail entry
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = free_reg;
                    end
                end
            end
            dltq_pkg::S_WALK:
            begin
                if (cmd_reg.mode == dltq_pkg::MODE_SET)
                begin
                    if (delta_rdata > dly_reg)
                    begin
                        // split the following delta
                        alu_a       = delta_rdata;
                        alu_b       = dly_reg;
                        delta_we    = 1'b1;
                        delta_waddr = cur_reg;
                        // previous entry now points at the new one
                        link_we     = (prev_reg != EMPTY);
                        link_waddr  = prev_reg;
                        link_wdata  = free_reg;
                    end
                    else
                    begin
                        dly_next  = alu_y[15:0];
                        prev_next = cur_reg;
                        cur_next  = link_rdata;
                    end
                end
                else if (is_match)
                begin
                    ent_next   = link_rdata;
                    cdelta_next = delta_rdata;
                    link_we    = 1'b1;
                    link_waddr = cur_reg;
                    link_wdata = free_reg;
                    free_next  = cur_reg;
                    if (prev_reg == EMPTY)
                        head_next = link_rdata;
                    raddr = link_rdata;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rdata;
                end
            end
            dltq_pkg::S_DEL_FIX:
            begin
                // unlink from previous, then add delta into next entry
                link_we     = (prev_reg != EMPTY);
                link_waddr  = prev_reg;
                link_wdata  = ent_reg;
                alu_sub     = 1'b0;
                alu_a       = delta_rdata;
                alu_b       = cdelta_reg;
                delta_we    = (ent_reg != EMPTY);
                delta_waddr = ent_reg;
                delta_wdata = alu_y[16] ? 16'hFFFF : alu_y[15:0];
                ovalid_next = 1'b1;
            end
            dltq_pkg::S_SET_END:
            begin
                // link free entry in; free list link comes from ent_reg
                link_we     = 1'b1;
                link_waddr  = free_reg;
                link_wdata  = cur_reg;
                delta_we    = 1'b1;
                delta_waddr = free_reg;
                delta_wdata = dly_reg;
                data_we     = 1'b1;
                free_next   = ent_reg;
                if (prev_reg == EMPTY)
                    head_next = free_reg;
                ovalid_next = 1'b1;
            end
            dltq_pkg::S_TICK_HEAD:
            begin
                // decrement head on the first pass only, look ahead at next delta
                alu_a = delta_rdata;
                alu_b = 16'd1;
                cdelta_next = delta_rdata;
                ent_next = link_rdata;
                raddr    = link_rdata;
                out_next = '{status: dltq_pkg::ST_EXPIRED, event_queue: queue_rdata,
                             event_message: message_rdata, last: 1'b0};
                if (cnt_reg == '0 && delta_rdata != 16'd0)
                begin
                    delta_we    = 1'b1;
                    delta_waddr = head_reg;
                    cdelta_next = alu_y[15:0];
                end
            end
            dltq_pkg::S_TICK_CHK:
            begin
                if (cdelta_reg == 16'd0)
                begin
                    link_we    = 1'b1;
                    link_waddr = head_reg;
                    link_wdata = free_reg;
                    free_next  = head_reg;
                    head_next  = ent_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    out_next.last = (ent_reg == EMPTY) || (delta_rdata != 16'd0)
                                    || (cnt_reg == CW'(dltq_pkg::MAX_RESULTS - 1));
                end
                else
                    out_next = '{status: dltq_pkg::ST_IDLE, event_queue: 8'd0,
                                 event_message: 32'd0, last: 1'b1};
                ovalid_next = 1'b1;
            end
            dltq_pkg::S_OUT:
            begin
                raddr = head_reg;
                if (ovalid_reg && rsp.ready)
                    ovalid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    `DLTQ_ASSERT_IMP(a_ready_idle, clk, rst_n, req.ready, !ovalid_reg)
    `DLTQ_ASSERT_IMP(a_head_range, clk, rst_n, 1'b1, head_reg <= EMPTY)
    `DLTQ_ASSERT_IMP(a_free_range, clk, rst_n, 1'b1, free_reg <= EMPTY)
    `DLTQ_ASSERT_NEXT(a_out_hold, clk, rst_n, rsp.valid && !rsp.ready,
                      rsp.valid && $stable(out_reg))
endmodule

// File: tb/sv/tb_delta_list_timer_queue.sv
`timescale 1ns / 100ps
module tb_delta_list_timer_queue;

    localparam int NENT = 16;
    localparam int EMPTY = NENT;
    localparam int WDOG_LIMIT = 20000;

    // scoreboard holding a private copy of the event table
    class timer_scoreboard;
        int unsigned nxt [NENT];
        int unsigned dlt [NENT];
        logic [7:0]  qid [NENT];
        logic [31:0] msg [NENT];
        int unsigned free_hd;
        int unsigned list_hd;
        dltq_pkg::rsp_t pending [$];
        int          errors;

        function void clear();
            for (int i = 0; i < NENT; i++)
            begin
                nxt[i] = i + 1;
                dlt[i] = 0;
                qid[i] = '0;
                msg[i] = '0;
            end
            free_hd = 0;
            list_hd = EMPTY;
            pending.delete();
            errors = 0;
        endfunction

        function void push(logic [2:0] st, logic [7:0] q, logic [31:0] m, logic lst);
            dltq_pkg::rsp_t r;
            r.status = st;
            r.event_queue = q;
            r.event_message = m;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function logic [2:0] insert_event(int unsigned d, logic [7:0] q, logic [31:0] m);
            int unsigned e;
            int unsigned cur;
            int unsigned prv;
            if (free_hd >= NENT)
                return dltq_pkg::ST_FULL;
            e = free_hd;
            free_hd = nxt[e];
            qid[e] = q;
            msg[e] = m;
            prv = EMPTY;
            cur = list_hd;
            for (int g = 0; g < NENT && cur < NENT; g++)
            begin
                if (dlt[cur] > d)
                begin
                    dlt[cur] -= d;
                    break;
                end
                d -= dlt[cur];
                prv = cur;
                cur = nxt[cur];
            end
            if (prv < NENT)
                nxt[prv] = e;
            else
                list_hd = e;
            nxt[e] = (cur < NENT) ? cur : EMPTY;
            dlt[e] = d;
            return dltq_pkg::ST_OK;
        endfunction

        function logic [2:0] remove_event(logic [7:0] q, logic [31:0] m);
            int unsigned cur;
            int unsigned prv;
            int unsigned n;
            int unsigned s;
            cur = list_hd;
            prv = EMPTY;
            for (int g = 0; g < NENT && cur < NENT; g++)
            begin
                if (qid[cur] == q && msg[cur] == m)
                begin
                    n = nxt[cur];
                    if (prv < NENT)
                        nxt[prv] = n;
                    else
                        list_hd = n;
                    if (n < NENT)
                    begin
                        s = dlt[n] + dlt[cur];
                        dlt[n] = (s > 65535) ? 65535 : s;
                    end
                    nxt[cur] = free_hd;
                    free_hd = cur;
                    return dltq_pkg::ST_OK;
                end
                prv = cur;
                cur = nxt[cur];
            end
            return dltq_pkg::ST_NOT_FOUND;
        endfunction

        // note an accepted request and queue its expected responses
        function void note_request(dltq_pkg::req_t rq);
            int n;
            int unsigned h;
            case (rq.mode)
                dltq_pkg::MODE_SET:
                    push(insert_event(rq.delay, rq.queue_id, rq.message), 8'd0, 32'd0, 1'b1);
                dltq_pkg::MODE_DELETE:
                    push(remove_event(rq.queue_id, rq.message), 8'd0, 32'd0, 1'b1);
                dltq_pkg::MODE_TICK:
                begin
                    n = 0;
                    if (list_hd < NENT && dlt[list_hd] > 0)
                        dlt[list_hd] -= 1;
                    while (n < dltq_pkg::MAX_RESULTS && list_hd < NENT && dlt[list_hd] == 0)
                    begin
                        h = list_hd;
                        n++;
                        list_hd = nxt[h];
                        nxt[h] = free_hd;
                        free_hd = h;
                        push(dltq_pkg::ST_EXPIRED, qid[h], msg[h],
                             !(n < dltq_pkg::MAX_RESULTS && list_hd < NENT
                               && dlt[list_hd] == 0));
                    end
                    if (n == 0)
                        push(dltq_pkg::ST_IDLE, 8'd0, 32'd0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_response(dltq_pkg::rsp_t got);
            dltq_pkg::rsp_t ex;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response %p", $time, got);
                errors++;
                return;
            end
            ex = pending.pop_front();
            if (got.status !== ex.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, ex.status, got.status);
                errors++;
            end
            if (got.event_queue !== ex.event_queue)
            begin
                $display("%0t: event_queue expected %0d actual %0d", $time,
                         ex.event_queue, got.event_queue);
                errors++;
            end
            if (got.event_message !== ex.event_message)
            begin
                $display("%0t: event_message expected %h actual %h", $time,
                         ex.event_message, got.event_message);
                errors++;
            end
            if (got.last !== ex.last)
            begin
                $display("%0t: last expected %0b actual %0b", $time, ex.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dltq_req_if req_ch ();
    dltq_rsp_if rsp_ch ();

    delta_list_timer_queue #(.NUM_ENTRIES(NENT)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    timer_scoreboard sb;
    int  idle_cycles;
    bit  calm;
    bit  hold_rsp;
    int  hold_left;
    // recently set events, used to aim deletes at live entries
    logic [7:0]  recent_q [$];
    logic [31:0] recent_m [$];

    always #4 clk = ~clk;

    // sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.payload);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.payload);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // response ready with random stall bursts and forced long hold-offs
    always @(negedge clk)
    begin
        if (hold_rsp)
            rsp_ch.ready <= 1'b0;
        else if (!calm && $urandom_range(0, 5) == 0)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= 1'b1;
    end

    initial
    begin
        hold_rsp = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                hold_rsp = (hold_left > 0);
            end
            else if (!calm && $urandom_range(0, 40) == 0)
            begin
                hold_left = $urandom_range(1, 12);
                hold_rsp = 1;
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (idle_cycles > WDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] md, logic [15:0] d, logic [7:0] q,
                                logic [31:0] m);
        dltq_pkg::req_t rq;
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rq.mode = md;
        rq.delay = d;
        rq.queue_id = q;
        rq.message = m;
        req_ch.payload <= rq;
        req_ch.valid <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if (md == dltq_pkg::MODE_SET)
        begin
            recent_q.push_back(q);
            recent_m.push_back(m);
            if (recent_q.size() > 24)
            begin
                void'(recent_q.pop_front());
                void'(recent_m.pop_front());
            end
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic random_request();
        int sel;
        int k;
        logic [15:0] d;
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: d = 16'($urandom_range(0, 3));
            1: d = 16'($urandom_range(0, 20));
            2: d = 16'($urandom);
            default: d = 16'($urandom_range(0, 8));
        endcase
        if (sel < 40)
            send_request(dltq_pkg::MODE_SET, d, 8'($urandom), 32'($urandom));
        else if (sel < 55 && recent_q.size() > 0)
        begin
            k = $urandom_range(0, recent_q.size() - 1);
            send_request(dltq_pkg::MODE_DELETE, '0, recent_q[k], recent_m[k]);
        end
        else if (sel < 60)
            send_request(dltq_pkg::MODE_DELETE, 16'($urandom), 8'($urandom), 32'($urandom));
        else if (sel < 97)
            send_request(dltq_pkg::MODE_TICK, 16'($urandom), 8'($urandom), 32'($urandom));
        else
            send_request(dltq_pkg::MODE_UNUSED, 16'($urandom), 8'($urandom),
                         32'($urandom));
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        clk = 1'b0;
        rst_n = 1'b0;
        calm = 1'b0;
        idle_cycles = 0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty tick, miss delete, equal delays, extremes
        send_request(dltq_pkg::MODE_TICK, '0, '0, '0);
        send_request(dltq_pkg::MODE_DELETE, '0, 8'hFF, 32'hFFFF_FFFF);
        send_request(dltq_pkg::MODE_SET, 16'd2, 8'd1, 32'h8000_0000);
        send_request(dltq_pkg::MODE_SET, 16'd2, 8'd2, 32'h7FFF_FFFF);
        send_request(dltq_pkg::MODE_SET, 16'd0, 8'd3, 32'd0);
        send_request(dltq_pkg::MODE_SET, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(dltq_pkg::MODE_SET, 16'hFFFF, 8'd0, 32'd5);
        send_request(dltq_pkg::MODE_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        // deleting the first max-delay entry folds its delta into the next entry
        send_request(dltq_pkg::MODE_DELETE, '0, 8'hFF, 32'hFFFF_FFFF);
        send_request(dltq_pkg::MODE_TICK, '0, '0, '0);
        send_request(dltq_pkg::MODE_TICK, '0, '0, '0);
        send_request(dltq_pkg::MODE_TICK, '0, '0, '0);
        drain();

        // fill the table with 17 zero-delay events: full, then burst cap
        for (int i = 0; i < 17; i++)
            send_request(dltq_pkg::MODE_SET, '0, 8'(i), 32'(32'h100 + i));
        drain();
        // long receiver hold-off while requests keep coming
        hold_left = 400;
        hold_rsp = 1;
        send_request(dltq_pkg::MODE_TICK, '0, '0, '0);
        for (int i = 0; i < 10; i++)
            send_request(dltq_pkg::MODE_SET, 16'(i), 8'(8'hA0 + i), 32'($urandom));
        send_request(dltq_pkg::MODE_TICK, '0, '0, '0);
        drain();

        // random traffic
        for (int i = 0; i < 370; i++)
        begin
            if (i == 300)
                calm = 1'b1;
            if (i == 180)
                drain();
            random_request();
        end
        // flush the list
        for (int i = 0; i < 40; i++)
            send_request(dltq_pkg::MODE_TICK, '0, '0, '0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
